// ===== sv/obb_pkg.sv =====
// ----------------------------------------------------------------------------
// obb_pkg
// shared constants and cordic arctangent table for the oriented box test
// ----------------------------------------------------------------------------
package obb_pkg;

	localparam int FRAC_BITS_DEF  = 8;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int CORDIC_STEPS   = 16;
	localparam int POS_W          = 24;
	localparam int LEN_W          = 23;
	localparam int TRIG_W         = 16;   // q2.14 signed
	localparam int CW             = 34;   // cordic datapath width
	localparam logic signed [CW-1:0] CORDIC_GAIN_START = 34'sd652032874;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		begin
			unique case (i)
				0: r = 32'h20000000;
				1: r = 32'h12E4051E;
				2: r = 32'h09FB385B;
				3: r = 32'h051111D4;
				4: r = 32'h028B0D43;
				5: r = 32'h0145D7E1;
				6: r = 32'h00A2F61E;
				7: r = 32'h00517C55;
				8: r = 32'h0028BE53;
				9: r = 32'h00145F2F;
				10: r = 32'h000A2F98;
				11: r = 32'h000517CC;
				12: r = 32'h00028BE6;
				13: r = 32'h000145F3;
				14: r = 32'h0000A2FA;
				default: r = 32'h0000517D;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== sv/obb_overlap_test_2d.sv =====
// ----------------------------------------------------------------------------
// obb_overlap_test_2d
// separating axis overlap test for two rotated rectangles, fully pipelined
// ----------------------------------------------------------------------------
// Takes one box pair per clock whenever start is high; busy is always low, so
// no pair is ever refused. The verdict appears on overlap with done high once the
// pair has passed 16 cordic rotation stages, which give the cosines and sines, and
// then 8 stages: the registered axes, the axis dot products and the dot products
// with the doubled center difference, the products with the sizes, the sums and the final compare.
// Results cannot be stalled; the receiver must take each one in its cycle.
module obb_overlap_test_2d #(
	// coordinates share one format, so the fraction width never enters the logic
	parameter int ANGLE_BITS = obb_pkg::ANGLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [obb_pkg::POS_W-1:0]     a_pos_x,
	input  logic signed [obb_pkg::POS_W-1:0]     a_pos_y,
	input  logic        [obb_pkg::LEN_W-1:0]     a_width,
	input  logic        [obb_pkg::LEN_W-1:0]     a_height,
	input  logic        [ANGLE_BITS-1:0]         a_angle,
	input  logic signed [obb_pkg::POS_W-1:0]     b_pos_x,
	input  logic signed [obb_pkg::POS_W-1:0]     b_pos_y,
	input  logic        [obb_pkg::LEN_W-1:0]     b_width,
	input  logic        [obb_pkg::LEN_W-1:0]     b_height,
	input  logic        [ANGLE_BITS-1:0]         b_angle,
	output logic                                 done,
	output logic                                 overlap
);

	localparam int N   = obb_pkg::CORDIC_STEPS;
	localparam int CW  = obb_pkg::CW;
	localparam int TW  = obb_pkg::TRIG_W;
	localparam int DW  = 27;  // doubled center difference
	localparam int PW  = 43;  // dot product d.u
	localparam int AW  = 30;  // |axis dot axis| up to 2^29
	localparam int LW  = 53;  // len * axis dot
	localparam int SW  = 56;  // sums and lhs

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic        [1:0]    q;
	} cordic_t;

	typedef struct packed {
		logic signed [DW-1:0]    dx;
		logic signed [DW-1:0]    dy;
		logic [3:0][obb_pkg::LEN_W-1:0] len;
	} geom_t;

	assign busy = 1'b0;

	// ---------------- cordic stages (both boxes in parallel) ---------------
	cordic_t  ca_s [0:N];
	cordic_t  cb_s [0:N];
	geom_t    g_s  [0:N];
	logic     v_s  [0:N];

	function automatic cordic_t cordic_init(input logic [ANGLE_BITS-1:0] ang);
		logic [31:0] turn;
		cordic_t     c;
		begin
			turn = {ang, {(32-ANGLE_BITS){1'b0}}};
			c.q  = turn[31:30];
			c.z  = CW'({2'b00, turn[29:0]});
			c.x  = obb_pkg::CORDIC_GAIN_START;
			c.y  = '0;
			return c;
		end
	endfunction

	function automatic cordic_t cordic_step(input cordic_t c, input int i);
		cordic_t r;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] at;
		begin
			dx = c.y >>> i;
			dy = c.x >>> i;
			at = CW'({2'b00, obb_pkg::atan_turn(i)});
			r  = c;
			if (!c.z[CW-1]) begin
				r.x = c.x - dx; r.y = c.y + dy; r.z = c.z - at;
			end else begin
				r.x = c.x + dx; r.y = c.y - dy; r.z = c.z + at;
			end
			return r;
		end
	endfunction

	always_comb begin
		ca_s[0] = cordic_init(a_angle);
		cb_s[0] = cordic_init(b_angle);
		v_s[0]  = start;
		g_s[0].dx = DW'(2 * DW'(signed'(b_pos_x)) + DW'(b_width))
		          - DW'(2 * DW'(signed'(a_pos_x)) + DW'(a_width));
		g_s[0].dy = DW'(2 * DW'(signed'(b_pos_y)) + DW'(b_height))
		          - DW'(2 * DW'(signed'(a_pos_y)) + DW'(a_height));
		g_s[0].len = {b_height, b_width, a_height, a_width};
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			ca_s[i+1] <= cordic_step(ca_s[i], i);
			cb_s[i+1] <= cordic_step(cb_s[i], i);
			g_s[i+1]  <= g_s[i];
		end
	end

	// ---------------- round and quadrant -------------------------------------
	function automatic logic signed [TW-1:0] rnd(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		begin
			t = (v + CW'(32768)) >>> 16;
			return TW'(t);
		end
	endfunction

	logic signed [TW-1:0] ax_c [4];
	logic signed [TW-1:0] ay_c [4];
	logic signed [TW-1:0] cr_a, sr_a, cr_b, sr_b, c_a, s_a, c_b, s_b;

	always_comb begin
		cr_a = rnd(ca_s[N].x); sr_a = rnd(ca_s[N].y);
		cr_b = rnd(cb_s[N].x); sr_b = rnd(cb_s[N].y);
		unique case (ca_s[N].q)
			2'd0: begin c_a = cr_a;  s_a = sr_a;  end
			2'd1: begin c_a = -sr_a; s_a = cr_a;  end
			2'd2: begin c_a = -cr_a; s_a = -sr_a; end
			default: begin c_a = sr_a; s_a = -cr_a; end
		endcase
		unique case (cb_s[N].q)
			2'd0: begin c_b = cr_b;  s_b = sr_b;  end
			2'd1: begin c_b = -sr_b; s_b = cr_b;  end
			2'd2: begin c_b = -cr_b; s_b = -sr_b; end
			default: begin c_b = sr_b; s_b = -cr_b; end
		endcase
		ax_c[0] = c_a;  ay_c[0] = s_a;
		ax_c[1] = -s_a; ay_c[1] = c_a;
		ax_c[2] = c_b;  ay_c[2] = s_b;
		ax_c[3] = -s_b; ay_c[3] = c_b;
	end

	// stage t1: registered axes
	logic signed [TW-1:0] ax_t1 [4];
	logic signed [TW-1:0] ay_t1 [4];
	geom_t g_t1;
	logic  v_t1;

	// stage t2: products of axes and of the difference
	logic signed [2*TW-1:0] pxx_t2 [4][4];
	logic signed [2*TW-1:0] pyy_t2 [4][4];
	logic signed [PW-1:0]   dxu_t2 [4];
	logic signed [PW-1:0]   dyu_t2 [4];
	geom_t g_t2;
	logic  v_t2;

	// stage t3: dot sums and absolute values
	logic [AW-1:0]        dot_t3 [4][4];
	logic [PW-1:0]        dabs_t3 [4];
	geom_t g_t3;
	logic  v_t3;

	// stage t4: len times |dot|, lhs scaled
	logic [LW-1:0] lp_t4 [4][4];
	logic [SW-1:0] lhs_t4 [4];
	logic          v_t4;

	// stage t5: partial sums
	logic [SW-1:0] ps_t5 [4][2];
	logic [SW-1:0] lhs_t5 [4];
	logic          v_t5;

	// stage t6: rhs sums
	logic [SW-1:0] rhs_t6 [4];
	logic [SW-1:0] lhs_t6 [4];
	logic          v_t6;

	// stage t7: per axis separation flags
	logic [3:0] sep_t7;
	logic       v_t7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1 <= 1'b0; v_t2 <= 1'b0; v_t3 <= 1'b0; v_t4 <= 1'b0;
			v_t5 <= 1'b0; v_t6 <= 1'b0; v_t7 <= 1'b0; done <= 1'b0;
		end else begin
			v_t1 <= v_s[N]; v_t2 <= v_t1; v_t3 <= v_t2; v_t4 <= v_t3;
			v_t5 <= v_t4;   v_t6 <= v_t5; v_t7 <= v_t6; done <= v_t7;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			ax_t1[k] <= ax_c[k];
			ay_t1[k] <= ay_c[k];
		end
		g_t1 <= g_s[N];

		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 4; j++) begin
				pxx_t2[k][j] <= ax_t1[j] * ax_t1[k];
				pyy_t2[k][j] <= ay_t1[j] * ay_t1[k];
			end
			dxu_t2[k] <= PW'(g_t1.dx) * PW'(ax_t1[k]);
			dyu_t2[k] <= PW'(g_t1.dy) * PW'(ay_t1[k]);
		end
		g_t2 <= g_t1;

		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 4; j++) begin
				logic signed [2*TW:0] d;
				d = (2*TW+1)'(pxx_t2[k][j]) + (2*TW+1)'(pyy_t2[k][j]);
				dot_t3[k][j] <= d[2*TW] ? AW'(-d) : AW'(d);
			end
			begin
				logic signed [PW-1:0] p;
				p = dxu_t2[k] + dyu_t2[k];
				dabs_t3[k] <= p[PW-1] ? PW'(-p) : PW'(p);
			end
		end
		g_t3 <= g_t2;

		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 4; j++)
				lp_t4[k][j] <= LW'(g_t3.len[j]) * LW'(dot_t3[k][j]);
			lhs_t4[k] <= {SW'(dabs_t3[k])} << 14;
		end

		for (int k = 0; k < 4; k++) begin
			ps_t5[k][0] <= SW'(lp_t4[k][0]) + SW'(lp_t4[k][1]);
			ps_t5[k][1] <= SW'(lp_t4[k][2]) + SW'(lp_t4[k][3]);
			lhs_t5[k]   <= lhs_t4[k];
		end

		for (int k = 0; k < 4; k++) begin
			rhs_t6[k] <= ps_t5[k][0] + ps_t5[k][1];
			lhs_t6[k] <= lhs_t5[k];
		end

		for (int k = 0; k < 4; k++)
			sep_t7[k] <= (lhs_t6[k] >= rhs_t6[k]);

		overlap <= ~|sep_t7;
	end

endmodule

// ===== sv/obb_checker.sv =====
// ----------------------------------------------------------------------------
// obb_checker
// port level checks for obb_overlap_test_2d
// ----------------------------------------------------------------------------
module obb_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	localparam int LAT = 24;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("result missing");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without transfer");

endmodule

bind obb_overlap_test_2d obb_checker u_obb_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);

// ===== tb/obb_overlap_test_2d_tb.sv =====
// ----------------------------------------------------------------------------
// obb_overlap_test_2d_tb
// checks the oriented box overlap verdict against an independent fixed-point
// prediction for directed corner cases and random box pairs
// ----------------------------------------------------------------------------
module obb_overlap_test_2d_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PW_TB = obb_pkg::POS_W;
	localparam int LW_TB = obb_pkg::LEN_W;

	typedef struct {
		logic signed [PW_TB-1:0] ax, ay, bx, by;
		logic [LW_TB-1:0] aw, ah, bw, bh;
		logic [15:0] aa, ba;
	} box_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, overlap;
	logic signed [PW_TB-1:0] a_pos_x = '0, a_pos_y = '0, b_pos_x = '0, b_pos_y = '0;
	logic [LW_TB-1:0] a_width = '0, a_height = '0, b_width = '0, b_height = '0;
	logic [15:0] a_angle = '0, b_angle = '0;

	bit verdict_q[$];
	int errors = 0;
	int pairs_sent = 0;
	int verdicts_seen = 0;
	int overlaps_seen = 0;
	int gap_pct = 0;

	obb_overlap_test_2d uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_pos_x(a_pos_x), .a_pos_y(a_pos_y), .a_width(a_width), .a_height(a_height),
		.a_angle(a_angle), .b_pos_x(b_pos_x), .b_pos_y(b_pos_y), .b_width(b_width),
		.b_height(b_height), .b_angle(b_angle), .done(done), .overlap(overlap)
	);

	always #6 clk = ~clk;

	initial begin
		#50ms;
		$display("timeout at %0t", $time);
		$display("Regression FAIL");
		$finish;
	end

	function automatic longint shr_floor(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	// cordic cosine/sine in q2.14
	task automatic cos_sin(input logic [15:0] ang, output longint c, output longint s);
		logic [31:0] turn;
		longint x, y, z, dx, dy, cr, sr;
		begin
			turn = {ang, 16'h0};
			x = 652032874;
			y = 0;
			z = longint'(turn[29:0]);
			for (int i = 0; i < obb_pkg::CORDIC_STEPS; i++) begin
				dx = shr_floor(y, i);
				dy = shr_floor(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(obb_pkg::atan_turn(i));
				end else begin
					x += dx; y -= dy; z += longint'(obb_pkg::atan_turn(i));
				end
			end
			cr = shr_floor(x + 32768, 16);
			sr = shr_floor(y + 32768, 16);
			case (turn[31:30])
				2'd0: begin c = cr; s = sr; end
				2'd1: begin c = -sr; s = cr; end
				2'd2: begin c = -cr; s = -sr; end
				default: begin c = sr; s = -cr; end
			endcase
		end
	endtask

	task automatic predict_overlap(input box_pair_t p, output bit hit);
		longint ux[4], uy[4], sz[4];
		longint ca, sa, cb, sb, dx, dy, lhs, rhs;
		bit sep;
		begin
			cos_sin(p.aa, ca, sa);
			cos_sin(p.ba, cb, sb);
			ux[0] = ca; uy[0] = sa; ux[1] = -sa; uy[1] = ca;
			ux[2] = cb; uy[2] = sb; ux[3] = -sb; uy[3] = cb;
			sz[0] = longint'(p.aw); sz[1] = longint'(p.ah);
			sz[2] = longint'(p.bw); sz[3] = longint'(p.bh);
			dx = (2 * longint'(p.bx) + sz[2]) - (2 * longint'(p.ax) + sz[0]);
			dy = (2 * longint'(p.by) + sz[3]) - (2 * longint'(p.ay) + sz[1]);
			sep = 1'b0;
			for (int k = 0; k < 4; k++) begin
				lhs = mag(dx * ux[k] + dy * uy[k]) * 16384;
				rhs = 0;
				for (int j = 0; j < 4; j++)
					rhs += sz[j] * mag(ux[j] * ux[k] + uy[j] * uy[k]);
				if (lhs >= rhs)
					sep = 1'b1;
			end
			hit = !sep;
		end
	endtask

	task automatic send_pair(input box_pair_t p);
		bit hit;
		begin
			while ($urandom_range(99) < gap_pct) begin
				start <= 1'b0;
				@(negedge clk);
			end
			a_pos_x <= p.ax; a_pos_y <= p.ay; a_width <= p.aw; a_height <= p.ah;
			a_angle <= p.aa; b_pos_x <= p.bx; b_pos_y <= p.by; b_width <= p.bw;
			b_height <= p.bh; b_angle <= p.ba;
			start <= 1'b1;
			@(posedge clk);
			while (busy) @(posedge clk);
			predict_overlap(p, hit);
			verdict_q.push_back(hit);
			pairs_sent++;
			@(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			verdicts_seen++;
			if (overlap) overlaps_seen++;
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected verdict, expected none, actual %0b", $time, overlap);
				errors++;
			end else begin
				bit exp_v;
				exp_v = verdict_q.pop_front();
				if (overlap !== exp_v) begin
					$display("%0t: overlap mismatch, expected %0b, actual %0b",
						$time, exp_v, overlap);
					errors++;
				end
			end
		end
	end

	function automatic box_pair_t mk(int ax, int ay, int aw, int ah, int aa,
			int bx, int by, int bw, int bh, int ba);
		box_pair_t p;
		p.ax = PW_TB'(ax); p.ay = PW_TB'(ay); p.aw = LW_TB'(aw); p.ah = LW_TB'(ah);
		p.aa = 16'(aa);
		p.bx = PW_TB'(bx); p.by = PW_TB'(by); p.bw = LW_TB'(bw); p.bh = LW_TB'(bh);
		p.ba = 16'(ba);
		return p;
	endfunction

	task automatic test_directed;
		begin
			send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));                 // zero size
			send_pair(mk(0, 0, 256, 256, 0, 256, 0, 256, 256, 0));       // touching edge
			send_pair(mk(0, 0, 512, 512, 0, 255, 0, 256, 256, 0));
			send_pair(mk(0, 0, 512, 512, 16384, 100, 100, 256, 256, 32768));
			send_pair(mk(0, 0, 512, 512, 49152, 100, 100, 256, 256, 65535));
			send_pair(mk(0, 0, 1000, 100, 8192, 300, 300, 1000, 100, 57344));
			send_pair(mk(-8388608, -8388608, 8388607, 8388607, 0,
				8388607, 8388607, 8388607, 8388607, 0));
			send_pair(mk(8388607, 8388607, 8388607, 8388607, 65535,
				-8388608, -8388608, 8388607, 8388607, 32768));
			send_pair(mk(-8388608, 8388607, 0, 8388607, 12345,
				8388607, -8388608, 8388607, 0, 54321));
			send_pair(mk(0, 0, 8388607, 8388607, 16383, 0, 0, 8388607, 8388607, 16385));
			send_pair(mk(-1, -1, 1, 1, 0, -1, -1, 1, 1, 0));
			send_pair(mk(0, 0, 256, 256, 0, 0, 256, 256, 256, 0));       // touching top
		end
	endtask

	task automatic test_random(input int n);
		box_pair_t p;
		int span;
		begin
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(9) < 2) begin
					p.ax = PW_TB'($urandom); p.ay = PW_TB'($urandom);
					p.bx = PW_TB'($urandom); p.by = PW_TB'($urandom);
					p.aw = LW_TB'($urandom); p.ah = LW_TB'($urandom);
					p.bw = LW_TB'($urandom); p.bh = LW_TB'($urandom);
				end else begin
					// nearby boxes so both verdicts turn up often
					span = 1 << $urandom_range(8, 22);
					p.ax = PW_TB'($signed($urandom_range(2 * span)) - span);
					p.ay = PW_TB'($signed($urandom_range(2 * span)) - span);
					p.bx = PW_TB'(p.ax + $signed($urandom_range(2 * span)) - span);
					p.by = PW_TB'(p.ay + $signed($urandom_range(2 * span)) - span);
					p.aw = LW_TB'($urandom_range(span)); p.ah = LW_TB'($urandom_range(span));
					p.bw = LW_TB'($urandom_range(span)); p.bh = LW_TB'($urandom_range(span));
				end
				p.aa = 16'($urandom); p.ba = 16'($urandom);
				send_pair(p);
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		gap_pct = 8;
		test_random(550);
		gap_pct = 85;
		test_random(500);
		gap_pct = 0;
		test_random(550);
		start <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("sent %0d box pairs, checked %0d verdicts, %0d overlapping",
			pairs_sent, verdicts_seen, overlaps_seen);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
